### rtl/lts_pkg.sv
// shared types and constants of the lower-triangular forward solver
// no dependencies; used by the divider and the top level
`default_nettype none

package lts_pkg;

  localparam logic REQ_COEF = 1'b0;
  localparam logic REQ_RHS  = 1'b1;

  localparam logic REG_SIZE_IN_USE = 1'b0;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  localparam logic [5:0] SIZE_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIAG_RD,
    ST_DIAG_LD,
    ST_DIV_WAIT,
    ST_XWR,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic        sat;
  } div_res_t;

endpackage

`default_nettype wire

### rtl/lts_if.sv
// valid/ready channel interfaces for coefficient/rhs requests and solution results
// no dependencies
`default_nettype none

interface lts_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [4:0]  row_index;
  logic [4:0]  col_index;
  logic signed [31:0] value;
  logic        last_of_vector;

  modport source (output valid, req_type, row_index, col_index, value, last_of_vector,
                  input ready);
  modport sink   (input valid, req_type, row_index, col_index, value, last_of_vector,
                  output ready);
endinterface

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  solution_index;
  logic signed [31:0] solution_value;
  logic        zero_diagonal;
  logic        saturated;
  logic        last_result;

  modport source (output valid, solution_index, solution_value, zero_diagonal, saturated,
                  last_result, input ready);
  modport sink   (input valid, solution_index, solution_value, zero_diagonal, saturated,
                  last_result, output ready);
endinterface

`default_nettype wire

### rtl/lower_triangular_forward_solve.sv
// lower-triangular forward solver: loads L and b into memories, solves L x = b in place
// per solve of order n: one serial divide per column with a nonzero diagonal, and a read,
// a multiply and a subtract-write per multiply-subtract update, then a read and a handoff per
// result transfer; inputs are taken one per cycle while idle, none during a solve
// reset clears control and sets size_in_use to 32; coefficient and rhs memories are not cleared
// depends on lts_pkg, lts_if, lts_ram, lts_div
`default_nettype none

module lower_triangular_forward_solve
  import lts_pkg::*;
#(
  parameter int MAX_ORDER     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lts_in_if.sink           req_i,
  lts_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IDX_W  = $clog2(MAX_ORDER);
  localparam int TRI_D  = MAX_ORDER * MAX_ORDER;
  localparam int TRI_AW = $clog2(TRI_D);
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);

  state_e state_q, state_d;

  logic [5:0]       size_q;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] k_q, k_d, i_q, i_d;
  logic [31:0]      x_q, x_d;
  logic [31:0]      b_q;
  logic signed [63:0] prod_q;
  logic [MAX_ORDER-1:0] sat_q, zd_q;

  logic       ov_q;
  logic [4:0] o_idx_q;
  logic [31:0] o_val_q;
  logic       o_zd_q, o_sat_q, o_last_q;

  // memory ports
  logic              rhs_we, rhs_re, tri_we, tri_re;
  logic [IDX_W-1:0]  rhs_waddr, rhs_raddr;
  logic [31:0]       rhs_wdata, rhs_rdata, tri_rdata;
  logic [TRI_AW-1:0] tri_waddr, tri_raddr;

  logic     div_start, div_busy;
  div_res_t div_res;

  // ---------------------------------------------------------------- config
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_q) : 32'd0;

  always_comb begin
    if (size_q == 6'd0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, size_q} > 7'(MAX_ORDER)) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else begin
      n_eff = CNT_W'(size_q);
    end
  end

  // ---------------------------------------------------------------- input decode
  logic       in_xfer, row_ok, col_ok;
  logic [6:0] row_x, col_x;
  assign in_xfer = req_i.valid && req_i.ready;
  assign row_x   = 7'(req_i.row_index);
  assign col_x   = 7'(req_i.col_index);
  assign row_ok  = row_x < 7'(MAX_ORDER);
  assign col_ok  = col_x < 7'(MAX_ORDER);

  logic [IDX_W-1:0] kx, ix, rowx, colx;
  assign kx   = k_q[IDX_W-1:0];
  assign ix   = i_q[IDX_W-1:0];
  assign rowx = row_x[IDX_W-1:0];
  assign colx = col_x[IDX_W-1:0];

  // ---------------------------------------------------------------- update arithmetic
  logic signed [63:0] p_shift;
  logic        [64:0] diff;
  logic               upd_sat;
  logic        [31:0] upd_val;

  assign p_shift = prod_q >>> FRACTION_BITS;
  assign diff    = {{33{b_q[31]}}, b_q} - {p_shift[63], p_shift};

  always_comb begin
    if (!diff[64] && (diff[63:31] != '0)) begin
      upd_sat = 1'b1;
      upd_val = WORD_MAX;
    end else if (diff[64] && (diff[63:31] != '1)) begin
      upd_sat = 1'b1;
      upd_val = WORD_MIN;
    end else begin
      upd_sat = 1'b0;
      upd_val = diff[31:0];
    end
  end

  logic out_free;
  assign out_free = !ov_q || res_o.ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    i_d     = i_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (req_i.req_type == REQ_RHS) && req_i.last_of_vector) begin
          state_d = ST_DIAG_RD;
          k_d     = '0;
        end
      end
      ST_DIAG_RD: state_d = ST_DIAG_LD;
      ST_DIAG_LD: state_d = (tri_rdata == 32'd0) ? ST_XWR : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_d = ST_XWR;
        end
      end
      ST_XWR: begin
        if (k_q + CNT_W'(1) < n_eff) begin
          i_d     = k_q + CNT_W'(1);
          state_d = ST_UPD_RD;
        end else begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_UPD_RD:  state_d = ST_UPD_MUL;
      ST_UPD_MUL: state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        if (i_q + CNT_W'(1) < n_eff) begin
          i_d     = i_q + CNT_W'(1);
          state_d = ST_UPD_RD;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ST_DIAG_RD;
        end
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        if (out_free) begin
          k_d = k_q + CNT_W'(1);
          state_d = (k_q + CNT_W'(1) == n_eff) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory and unit control
  always_comb begin
    rhs_we    = 1'b0;
    rhs_waddr = rowx;
    rhs_wdata = req_i.value;
    rhs_re    = 1'b0;
    rhs_raddr = kx;
    tri_we    = 1'b0;
    tri_waddr = TRI_AW'(rowx * MAX_ORDER + colx);
    tri_re    = 1'b0;
    tri_raddr = TRI_AW'(kx * MAX_ORDER + kx);
    div_start = 1'b0;
    x_d       = x_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tri_we = (req_i.req_type == REQ_COEF) && row_ok && col_ok;
          rhs_we = (req_i.req_type == REQ_RHS) && row_ok;
        end
      end
      ST_DIAG_RD: begin
        rhs_re = 1'b1;
        tri_re = 1'b1;
      end
      ST_DIAG_LD: begin
        if (tri_rdata == 32'd0) begin
          x_d = rhs_rdata[31] ? WORD_MIN : WORD_MAX;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          x_d = div_res.quot;
        end
      end
      ST_XWR: begin
        rhs_we    = 1'b1;
        rhs_waddr = kx;
        rhs_wdata = x_q;
      end
      ST_UPD_RD: begin
        rhs_re    = 1'b1;
        rhs_raddr = ix;
        tri_re    = 1'b1;
        tri_raddr = TRI_AW'(ix * MAX_ORDER + kx);
      end
      ST_UPD_WR: begin
        rhs_we    = 1'b1;
        rhs_waddr = ix;
        rhs_wdata = upd_val;
      end
      ST_OUT_RD: rhs_re = 1'b1;
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_RESET;
      k_q     <= '0;
      i_q     <= '0;
      ov_q    <= 1'b0;
      sat_q   <= '0;
      zd_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      if (cfg_wr) begin
        size_q <= pwdata[5:0];
      end
      if ((state_q == ST_OUT_LD) && out_free) begin
        ov_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (state_d == ST_DIAG_RD) begin
            sat_q <= '0;
            zd_q  <= '0;
          end
        end
        ST_DIAG_LD: begin
          if (tri_rdata == 32'd0) begin
            zd_q[kx]  <= 1'b1;
            sat_q[kx] <= 1'b1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_res.done && div_res.sat) begin
            sat_q[kx] <= 1'b1;
          end
        end
        ST_UPD_WR: begin
          if (upd_sat) begin
            sat_q[ix] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (state_q == ST_UPD_MUL) begin
      prod_q <= $signed(tri_rdata) * $signed(x_q);
      b_q    <= rhs_rdata;
    end
    if ((state_q == ST_OUT_LD) && out_free) begin
      o_idx_q  <= k_q[4:0];
      o_val_q  <= rhs_rdata;
      o_zd_q   <= zd_q[kx];
      o_sat_q  <= sat_q[kx];
      o_last_q <= (k_q + CNT_W'(1) == n_eff);
    end
  end

  assign res_o.valid          = ov_q;
  assign res_o.solution_index = o_idx_q;
  assign res_o.solution_value = o_val_q;
  assign res_o.zero_diagonal  = o_zd_q;
  assign res_o.saturated      = o_sat_q;
  assign res_o.last_result    = o_last_q;

  // ---------------------------------------------------------------- instances
  lts_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (rhs_waddr),
    .wdata_i (rhs_wdata),
    .re_i    (rhs_re),
    .raddr_i (rhs_raddr),
    .rdata_o (rhs_rdata)
  );

  lts_ram #(.WIDTH(32), .DEPTH(TRI_D)) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_waddr),
    .wdata_i (req_i.value),
    .re_i    (tri_re),
    .raddr_i (tri_raddr),
    .rdata_o (tri_rdata)
  );

  lts_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rhs_rdata),
    .divisor_i  (tri_rdata),
    .busy_o     (div_busy),
    .res_o      (div_res)
  );

  // ---------------------------------------------------------------- assertions
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !div_busy)
    else $error("input taken while divider busy");

  a_upd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR) |-> ($past(state_q) == ST_UPD_MUL))
    else $error("update write without multiply");

  a_upd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_RD) |-> ((i_q > k_q) && (i_q < n_eff)))
    else $error("update row out of range");

endmodule

`default_nettype wire

### rtl/lts_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/lts_div.sv
// iterative signed fixed-point divider, one quotient bit per cycle, saturating to 32 bits
// depends on lts_pkg
`default_nettype none

module lts_div
  import lts_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output div_res_t         res_o
);

  localparam int NUM_W = 32 + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h0_8000_0000);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [32:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic             neg_q, neg_d;

  logic [31:0] abs_b, abs_d;
  logic [32:0] rem_sh;
  logic        ge;

  assign abs_b  = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign abs_d  = divisor_i[31]  ? (~divisor_i + 32'd1)  : divisor_i;
  assign rem_sh = {rem_q[31:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = NUM_W'(abs_b) << FRACTION_BITS;
      rem_d  = '0;
      den_d  = abs_d;
      neg_d  = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      // restoring step: quotient bits shift in where dividend bits leave
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  logic sat_pos, sat_neg;
  assign sat_pos = num_q > POS_LIM;
  assign sat_neg = num_q > NEG_LIM;

  always_comb begin
    res_o.done = done_q;
    if (neg_q) begin
      res_o.sat  = sat_neg;
      res_o.quot = sat_neg ? WORD_MIN : (~num_q[31:0] + 32'd1);
    end else begin
      res_o.sat  = sat_pos;
      res_o.quot = sat_pos ? WORD_MAX : num_q[31:0];
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

### sim/lower_triangular_forward_solve_tb.sv
// testbench of the lower-triangular forward solver: loads L and b, solves, checks every x
// against an in-bench fixed-point forward substitution; depends on lts_pkg, lts_if and the rtl
`timescale 1ns / 100ps

module lower_triangular_forward_solve_tb;
  import lts_pkg::*;

  localparam int ORDER = 32;
  localparam int LOAD_ORDER = 16;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 280;

  typedef struct {
    logic [4:0]  idx;
    logic [31:0] val;
    logic        zdiag;
    logic        sat;
    logic        last;
  } solution_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lts_in_if  req_ch ();
  lts_out_if res_ch ();

  lower_triangular_forward_solve dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the block state
  logic signed [31:0] coef_mem [ORDER][ORDER];
  logic signed [31:0] rhs_mem [ORDER];
  logic [5:0] order_reg;
  solution_t solution_q [$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  bit tx_gaps = 1;
  bit rx_gaps = 1;
  int rx_hold_req = 0;
  int rx_stall = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic longint clamp_word(input longint v, inout bit sat);
    if (v > 64'sh7fff_ffff) begin
      sat = 1;
      return 64'sh7fff_ffff;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  // forward substitution over the mirrored stores, queues the n solution transfers
  function automatic void forward_solve_predict();
    int n;
    longint b, d, x, p, u;
    bit sat [ORDER];
    bit zd [ORDER];
    solution_t s;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > ORDER) n = ORDER;
    for (int k = 0; k < ORDER; k++) begin
      sat[k] = 0;
      zd[k] = 0;
    end
    for (int k = 0; k < n; k++) begin
      b = rhs_mem[k];
      d = coef_mem[k][k];
      if (d == 0) begin
        zd[k] = 1;
        sat[k] = 1;
        x = (b >= 0) ? 64'sh7fff_ffff : -64'sh8000_0000;
      end else begin
        x = clamp_word((b * (64'sd1 <<< FRAC)) / d, sat[k]);
      end
      rhs_mem[k] = x[31:0];
      for (int i = k + 1; i < n; i++) begin
        p = (longint'(coef_mem[i][k]) * x) >>> FRAC;
        u = clamp_word(longint'(rhs_mem[i]) - p, sat[i]);
        rhs_mem[i] = u[31:0];
      end
    end
    for (int k = 0; k < n; k++) begin
      s.idx = k[4:0];
      s.val = rhs_mem[k];
      s.zdiag = zd[k];
      s.sat = sat[k];
      s.last = (k == n - 1);
      solution_q.push_back(s);
    end
  endfunction

  // sampled at the falling edge, the transfer happens at the next rising edge
  always @(negedge clk_i) begin
    solution_t s;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (solution_q.size() == 0) begin
        report($sformatf("unexpected result index %0d", res_ch.solution_index));
      end else begin
        s = solution_q.pop_front();
        if (res_ch.solution_index !== s.idx)
          report($sformatf("index %0d, want %0d", res_ch.solution_index, s.idx));
        if (res_ch.solution_value !== s.val)
          report($sformatf("x%0d value %h, want %h", s.idx, res_ch.solution_value, s.val));
        if (res_ch.zero_diagonal !== s.zdiag)
          report($sformatf("x%0d zero_diagonal %b, want %b", s.idx, res_ch.zero_diagonal,
                           s.zdiag));
        if (res_ch.saturated !== s.sat)
          report($sformatf("x%0d saturated %b, want %b", s.idx, res_ch.saturated, s.sat));
        if (res_ch.last_result !== s.last)
          report($sformatf("x%0d last_result %b, want %b", s.idx, res_ch.last_result,
                           s.last));
      end
    end
  end

  // receiver side: random stalls plus a long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rx_hold_req > 0) begin
        rx_stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_stall > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (rx_gaps && r < 20) rx_stall = $urandom_range(1, 3);
        else if (rx_gaps && r < 23) rx_stall = $urandom_range(10, 40);
      end
    end
  end

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input logic rtype, input int row, input int col,
                           input logic [31:0] v, input logic last);
    int gap;
    int r;
    bit rdy;
    r = $urandom_range(0, 99);
    gap = 0;
    if (tx_gaps && r >= 55) gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rtype;
    req_ch.row_index <= row[4:0];
    req_ch.col_index <= col[4:0];
    req_ch.value <= v;
    req_ch.last_of_vector <= last;
    do begin
      @(negedge clk_i);
      rdy = req_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    items_sent++;
    if (rtype == REQ_COEF) begin
      coef_mem[row][col] = v;
    end else begin
      rhs_mem[row] = v;
      if (last) forward_solve_predict();
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_order(input logic [31:0] data);
    bit rdy;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SIZE_IN_USE, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    order_reg = data[5:0];
  endtask

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0;
    if (r < 13) return WORD_MAX;
    if (r < 18) return WORD_MIN;
    if (r < 60) return $urandom_range(0, 1 << 19) - (1 << 18);
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_diag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0;
    if (r < 10) return $urandom_range(1, 255);
    if (r < 50) return $urandom_range(1 << 15, 1 << 18);
    return -$urandom_range(1 << 15, 1 << 18);
  endfunction

  // every entry that a solve of the loaded order reads gets a value
  task automatic test_full_load();
    set_order(LOAD_ORDER);
    for (int i = 0; i < LOAD_ORDER; i++)
      for (int k = 0; k <= i; k++)
        send_item(REQ_COEF, i, k, (i == k) ? rand_diag() : rand_value(), 1'b0);
    for (int i = 0; i < LOAD_ORDER; i++)
      send_item(REQ_RHS, i, 0, rand_value(), i == LOAD_ORDER - 1);
  endtask

  task automatic test_directed();
    set_order(4);
    send_item(REQ_COEF, 0, 0, 32'h0001_0000, 1'b0);
    send_item(REQ_COEF, 1, 1, 32'h0000_0000, 1'b0);     // zero diagonal
    send_item(REQ_COEF, 1, 0, WORD_MIN, 1'b0);
    send_item(REQ_COEF, 2, 2, 32'h0000_0001, 1'b0);     // tiny divisor, quotient overflows
    send_item(REQ_COEF, 2, 0, WORD_MAX, 1'b1);          // last on a coefficient: no solve
    send_item(REQ_COEF, 2, 1, 32'hffff_0000, 1'b0);
    send_item(REQ_COEF, 3, 3, 32'hffff_8000, 1'b0);
    send_item(REQ_COEF, 3, 0, 32'h0002_0000, 1'b0);
    send_item(REQ_COEF, 0, 31, 32'h1234_5678, 1'b0);    // upper triangle, never read
    send_item(REQ_COEF, 31, 31, 32'h0001_0000, 1'b0);
    send_item(REQ_RHS, 0, 31, WORD_MAX, 1'b0);
    send_item(REQ_RHS, 1, 0, 32'h0000_0000, 1'b0);
    send_item(REQ_RHS, 2, 0, WORD_MIN, 1'b0);
    send_item(REQ_RHS, 3, 0, 32'hffff_ffff, 1'b0);
    send_item(REQ_RHS, 20, 0, 32'h5555_aaaa, 1'b1);     // beyond n, solve still runs
    send_item(REQ_RHS, 0, 0, WORD_MIN, 1'b0);
    send_item(REQ_RHS, 1, 0, WORD_MIN, 1'b1);           // negative rhs over zero diagonal
  endtask

  task automatic test_order_extremes();
    logic [31:0] sizes [3];
    sizes = '{32'd1, 32'd0, 32'(LOAD_ORDER)};
    foreach (sizes[j]) begin
      set_order(sizes[j]);
      send_item(REQ_RHS, 0, 0, rand_value(), 1'b1);
    end
  endtask

  task automatic test_backpressure();
    set_order(8);
    rx_hold_req = 800;
    send_item(REQ_RHS, 3, 0, rand_value(), 1'b1);
    // block is busy, so these wait at the input
    send_item(REQ_RHS, 1, 0, rand_value(), 1'b0);
    send_item(REQ_COEF, 5, 2, rand_value(), 1'b0);
    send_item(REQ_RHS, 7, 0, rand_value(), 1'b1);
    drain();
    send_item(REQ_RHS, 2, 0, rand_value(), 1'b1);
  endtask

  task automatic test_random();
    int n, r, cnt, row, col;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      n = (r < 80) ? $urandom_range(1, 8) :
          (r < 96) ? $urandom_range(9, LOAD_ORDER - 1) : LOAD_ORDER;
      set_order(n);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        cnt = $urandom_range(0, 5);
        repeat (cnt) begin
          row = $urandom_range(0, n - 1);
          col = $urandom_range(0, row);
          send_item(REQ_COEF, row, col, (row == col) ? rand_diag() : rand_value(), 1'b0);
        end
        cnt = $urandom_range(0, n);
        repeat (cnt) send_item(REQ_RHS, $urandom_range(0, n - 1), $urandom_range(0, 31),
                               rand_value(), 1'b0);
        // noise: upper-triangle loads, last on a coefficient
        if ($urandom_range(0, 4) == 0) begin
          row = $urandom_range(0, 30);
          send_item(REQ_COEF, row, $urandom_range(row + 1, 31), $urandom(),
                    1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 7) == 0) drain();
        send_item(REQ_RHS, $urandom_range(0, 31), $urandom_range(0, 31), rand_value(), 1'b1);
      end
    end
    tx_gaps = 1;
    rx_gaps = 1;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_COEF;
    req_ch.row_index = '0;
    req_ch.col_index = '0;
    req_ch.value = '0;
    req_ch.last_of_vector = 1'b0;
    order_reg = SIZE_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_load();
    test_directed();
    test_order_extremes();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(posedge clk_i);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lts_ram.sv
rtl/lts_div.sv
rtl/lower_triangular_forward_solve.sv
sim/lower_triangular_forward_solve_tb.sv
